/* rtl/mqrbs_pkg.sv */
// Shared types and constants of the multi-queue ring buffer with search.
// Field widths, request and status codes, controller state and the
// command/status structs between controller and datapath. No dependencies.
package mqrbs_pkg;

	// Field widths of one request item and one result item
	localparam int REQ_W  = 3;
	localparam int QIDX_W = 3;
	localparam int LOC_W  = 16;
	localparam int PAY_W  = 32;
	localparam int STAT_W = 2;
	localparam int LEN_W  = 4;
	localparam int ACT_W  = 4;

	// Stream widths, padded to whole bytes
	localparam int IN_BITS     = REQ_W + QIDX_W + LOC_W + PAY_W;
	localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS    = STAT_W + LOC_W + PAY_W + LEN_W + 1;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

	// Active queue count after reset
	localparam logic [ACT_W-1:0] ACT_RESET = 4'd8;

	typedef enum logic [REQ_W-1:0] {
		REQ_PUSH      = 3'd0,
		REQ_POP       = 3'd1,
		REQ_PEEK_HEAD = 3'd2,
		REQ_PEEK_TAIL = 3'd3,
		REQ_LENGTH    = 3'd4,
		REQ_SEARCH    = 3'd5
	} req_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_FULL      = 2'd1,
		STAT_EMPTY     = 2'd2,
		STAT_BAD_INDEX = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_FINISH
	} fsm_t;

	// Controller to datapath
	typedef struct packed {
		logic exec;      // execute the item on the input bus
		logic scan_rd;   // issue the next search read
		logic load_out;  // load the result register
	} ctl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic is_search; // item on the input bus is a location search
		logic hit;       // search read returned a live matching entry
		logic scan_end;  // every search read has been issued
		logic scan_done; // every search read issued and checked
	} dp_sts_t;

endpackage

/* rtl/multi_queue_ring_buffer_with_search_core.sv */
// Multi-queue ring buffer with location search: NUM_QUEUES circular FIFOs of
// QUEUE_DEPTH entries held in one entry RAM with registered read. One request
// is worked at a time. Push, pop, peek, length and rejected requests are
// executed on acceptance; the result register is then loaded with the RAM
// read data once it is free. A location search scans the entry RAM of the
// first min(active_queues, NUM_QUEUES) queues one slot per cycle, queue by
// queue, and stops at the first live hit. A result waiting in the output
// register does not block acceptance of the next request.
// Depends on mqrbs_pkg, mqrbs_ctrl, mqrbs_dp and mqrbs_ram.
module multi_queue_ring_buffer_with_search_core #(
	parameter int NUM_QUEUES  = 8,
	parameter int QUEUE_DEPTH = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// s_tdata: req_type[2:0], queue_index[5:3], location_id[21:6],
	// goal_payload[53:22], zero pad [55:54]
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [mqrbs_pkg::IN_TDATA_W-1:0]  s_tdata,
	// m_tdata: status[1:0], out_location[17:2], out_payload[49:18],
	// out_length[53:50], found[54], zero pad [55]
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [mqrbs_pkg::OUT_TDATA_W-1:0] m_tdata,
	// active_queues register
	input  logic                              cfg_we,
	input  logic [mqrbs_pkg::ACT_W-1:0]       cfg_wdata
);

	import mqrbs_pkg::*;

	ctl_cmd_t cmd;
	dp_sts_t  sts;

	mqrbs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mqrbs_dp #(
		.NUM_QUEUES  (NUM_QUEUES),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.out_data  (m_tdata)
	);

endmodule

/* rtl/mqrbs_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Read data holds when no read is issued. No package dependency.
module mqrbs_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/mqrbs_ctrl.sv */
// Controller state machine of the multi-queue ring buffer with search.
// Sequences execute, search scan and result load; depends on mqrbs_pkg.
module mqrbs_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	input  mqrbs_pkg::dp_sts_t   sts,
	output mqrbs_pkg::ctl_cmd_t  cmd
);

	import mqrbs_pkg::*;

	fsm_t state_q;
	fsm_t state_d;
	logic out_valid_q;
	logic out_free;

	assign out_free = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			FSM_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.exec = 1'b1;
					state_d  = sts.is_search ? FSM_SCAN : FSM_FINISH;
				end
			end
			FSM_SCAN: begin
				cmd.scan_rd = !sts.scan_end && !sts.hit;
				if (sts.hit || sts.scan_done) begin
					state_d = FSM_FINISH;
				end
			end
			FSM_FINISH: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = FSM_IDLE;
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	// Result valid: set on load, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	// A result is never overwritten before it is taken
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || m_tready))
		else $error("result register loaded while occupied");

	// A queue request goes straight to result load
	a_queue_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && !sts.is_search) |=> (state_q == FSM_FINISH))
		else $error("queue request did not go to finish");

	// A search hit ends the scan at once
	a_hit_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FSM_SCAN && sts.hit) |=> (state_q == FSM_FINISH))
		else $error("search kept scanning after a hit");
`endif

endmodule

/* rtl/mqrbs_dp.sv */
// Datapath of the multi-queue ring buffer with search: per-queue head and
// fill registers, entry RAM, search scan and result register.
// Depends on mqrbs_pkg and mqrbs_ram.
module mqrbs_dp #(
	parameter int NUM_QUEUES  = 8,
	parameter int QUEUE_DEPTH = 8
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  mqrbs_pkg::ctl_cmd_t                   cmd,
	output mqrbs_pkg::dp_sts_t                    sts,
	input  logic [mqrbs_pkg::IN_TDATA_W-1:0]      in_data,
	input  logic                                  cfg_we,
	input  logic [mqrbs_pkg::ACT_W-1:0]           cfg_wdata,
	output logic [mqrbs_pkg::OUT_TDATA_W-1:0]     out_data
);

	import mqrbs_pkg::*;

	localparam int QI_W    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
	localparam int SUM_W   = CNT_W + 1;
	localparam int ENTRIES = NUM_QUEUES * QUEUE_DEPTH;
	localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int NQ_W    = $clog2(NUM_QUEUES + 1);
	localparam int CW      = (NQ_W > ACT_W) ? NQ_W : ACT_W;
	localparam int ENT_W   = LOC_W + PAY_W;

	localparam logic [SUM_W-1:0] DEPTH_S  = SUM_W'(QUEUE_DEPTH);
	localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(QUEUE_DEPTH);
	localparam logic [AW-1:0]    DEPTH_A  = AW'(QUEUE_DEPTH);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CW-1:0]    NQ_MAX   = CW'(NUM_QUEUES);

	// Reduce a sum below twice the depth to a ring slot
	function automatic logic [PTR_W-1:0] wrap_slot(input logic [SUM_W-1:0] v);
		logic [SUM_W-1:0] r;
		r = (v >= DEPTH_S) ? v - DEPTH_S : v;
		return r[PTR_W-1:0];
	endfunction

	// Request fields
	logic [REQ_W-1:0]  in_req;
	logic [QIDX_W-1:0] in_q;
	logic [LOC_W-1:0]  in_loc;
	logic [PAY_W-1:0]  in_pay;

	assign in_req = in_data[REQ_W-1:0];
	assign in_q   = in_data[REQ_W +: QIDX_W];
	assign in_loc = in_data[REQ_W + QIDX_W +: LOC_W];
	assign in_pay = in_data[REQ_W + QIDX_W + LOC_W +: PAY_W];

	// State
	logic [ACT_W-1:0] active_q;
	logic [PTR_W-1:0] head_q [NUM_QUEUES];
	logic [CNT_W-1:0] fill_q [NUM_QUEUES];

	// Request decode
	logic [CW-1:0]    nq;
	logic [CW-1:0]    q_ext;
	logic             q_ok;
	logic [QI_W-1:0]  q_sel;
	logic [PTR_W-1:0] head_sel;
	logic [CNT_W-1:0] fill_sel;
	logic [SUM_W-1:0] tail_sum;
	logic [AW-1:0]    q_base;

	logic [STAT_W-1:0] dec_status;
	logic [LEN_W-1:0]  dec_len;
	logic              dec_use_ram;
	logic              do_push;
	logic              do_pop;
	logic [PTR_W-1:0]  rd_slot;

	// Entry RAM
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [ENT_W-1:0]  ram_wdata;
	logic              ram_re;
	logic [AW-1:0]     ram_raddr;
	logic [ENT_W-1:0]  ram_rdata;

	// Search scan
	logic [CW-1:0]    scan_q_q;
	logic [PTR_W-1:0] scan_slot_q;
	logic [QI_W-1:0]  scan_idx;
	logic [PTR_W-1:0] scan_head;
	logic [CNT_W-1:0] scan_fill;
	logic [SUM_W-1:0] scan_off;
	logic             scan_live;
	logic [AW-1:0]    scan_addr;
	logic             scan_valid_s1;
	logic             scan_live_s1;
	logic             hit;
	logic             found_q;
	logic [LOC_W-1:0] req_loc_q;

	// Pending result
	logic [STAT_W-1:0] res_status_q;
	logic [LEN_W-1:0]  res_len_q;
	logic              res_use_ram_q;
	logic              res_search_q;

	// Result register
	logic [STAT_W-1:0] out_status_q;
	logic [LOC_W-1:0]  out_loc_q;
	logic [PAY_W-1:0]  out_pay_q;
	logic [LEN_W-1:0]  out_len_q;
	logic              out_found_q;

	// Clamp the active count to the queues built
	assign nq = (CW'(active_q) > NQ_MAX) ? NQ_MAX : CW'(active_q);

	assign q_ext    = CW'(in_q);
	assign q_ok     = q_ext < nq;
	assign q_sel    = q_ext[QI_W-1:0];
	assign head_sel = head_q[q_sel];
	assign fill_sel = fill_q[q_sel];
	assign tail_sum = SUM_W'(head_sel) + SUM_W'(fill_sel);
	assign q_base   = AW'(q_sel) * DEPTH_A;

	// Classify the request and pick the result
	always_comb begin
		dec_status  = STAT_OK;
		dec_len     = '0;
		dec_use_ram = 1'b0;
		do_push     = 1'b0;
		do_pop      = 1'b0;
		rd_slot     = head_sel;
		if (in_req == REQ_SEARCH) begin
			dec_status = STAT_OK;
		end else if ((in_req > REQ_SEARCH) || !q_ok) begin
			dec_status = STAT_BAD_INDEX;
		end else begin
			case (req_t'(in_req))
				REQ_PUSH: begin
					if (fill_sel == DEPTH_C) begin
						dec_status = STAT_FULL;
						dec_len    = LEN_W'(fill_sel);
					end else begin
						do_push = 1'b1;
						dec_len = LEN_W'(fill_sel + CNT_W'(1));
					end
				end
				REQ_POP, REQ_PEEK_HEAD, REQ_PEEK_TAIL: begin
					if (fill_sel == '0) begin
						dec_status = STAT_EMPTY;
					end else begin
						dec_use_ram = 1'b1;
						if (in_req == REQ_PEEK_TAIL) begin
							rd_slot = wrap_slot(tail_sum - SUM_W'(1));
						end
						if (in_req == REQ_POP) begin
							do_pop  = 1'b1;
							dec_len = LEN_W'(fill_sel - CNT_W'(1));
						end else begin
							dec_len = LEN_W'(fill_sel);
						end
					end
				end
				REQ_LENGTH: begin
					dec_len = LEN_W'(fill_sel);
				end
				default: begin
					dec_status = STAT_BAD_INDEX;
				end
			endcase
		end
	end

	// Liveness of the slot under scan: offset from head below fill
	assign scan_idx  = scan_q_q[QI_W-1:0];
	assign scan_head = head_q[scan_idx];
	assign scan_fill = fill_q[scan_idx];
	assign scan_off  = SUM_W'(scan_slot_q) + ((scan_slot_q < scan_head) ? DEPTH_S : '0)
		- SUM_W'(scan_head);
	assign scan_live = scan_off < SUM_W'(scan_fill);
	assign scan_addr = AW'(scan_idx) * DEPTH_A + AW'(scan_slot_q);

	// RAM ports
	assign ram_we    = cmd.exec && do_push;
	assign ram_waddr = q_base + AW'(wrap_slot(tail_sum));
	assign ram_wdata = {in_pay, in_loc};
	assign ram_re    = (cmd.exec && dec_use_ram) || cmd.scan_rd;
	assign ram_raddr = cmd.scan_rd ? scan_addr : (q_base + AW'(rd_slot));

	mqrbs_ram #(
		.WIDTH (ENT_W),
		.DEPTH (ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign hit = scan_valid_s1 && scan_live_s1 && (ram_rdata[LOC_W-1:0] == req_loc_q);

	assign sts.is_search = (in_req == REQ_SEARCH);
	assign sts.hit       = hit;
	assign sts.scan_end  = scan_q_q >= nq;
	assign sts.scan_done = (scan_q_q >= nq) && !scan_valid_s1;

	// Active queue count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= ACT_RESET;
		end else if (cfg_we) begin
			active_q <= cfg_wdata;
		end
	end

	// Advance head and fill of the addressed queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_QUEUES; i++) begin
				head_q[i] <= '0;
				fill_q[i] <= '0;
			end
		end else if (cmd.exec) begin
			if (do_push) begin
				fill_q[q_sel] <= fill_sel + CNT_W'(1);
			end else if (do_pop) begin
				head_q[q_sel] <= wrap_slot(SUM_W'(head_sel) + SUM_W'(1));
				fill_q[q_sel] <= fill_sel - CNT_W'(1);
			end
		end
	end

	// Scan counters, read pipeline and hit flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q_q      <= '0;
			scan_slot_q   <= '0;
			scan_valid_s1 <= 1'b0;
			found_q       <= 1'b0;
		end else begin
			scan_valid_s1 <= cmd.scan_rd;
			if (cmd.exec) begin
				scan_q_q    <= '0;
				scan_slot_q <= '0;
				found_q     <= 1'b0;
			end else begin
				if (hit) begin
					found_q <= 1'b1;
				end
				if (cmd.scan_rd) begin
					if (scan_slot_q == LAST_PTR) begin
						scan_slot_q <= '0;
						scan_q_q    <= scan_q_q + CW'(1);
					end else begin
						scan_slot_q <= scan_slot_q + PTR_W'(1);
					end
				end
			end
		end
	end

	// Liveness travels with the read
	always_ff @(posedge clk) begin
		scan_live_s1 <= scan_live;
	end

	// Hold the decoded result and the search key
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			req_loc_q     <= in_loc;
			res_status_q  <= dec_status;
			res_len_q     <= dec_len;
			res_use_ram_q <= dec_use_ram;
			res_search_q  <= (in_req == REQ_SEARCH);
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_status_q <= res_status_q;
			out_loc_q    <= res_use_ram_q ? ram_rdata[LOC_W-1:0] : '0;
			out_pay_q    <= res_use_ram_q ? ram_rdata[ENT_W-1:LOC_W] : '0;
			out_len_q    <= res_len_q;
			out_found_q  <= res_search_q && found_q;
		end
	end

	assign out_data = OUT_TDATA_W'({out_found_q, out_len_q, out_pay_q, out_loc_q, out_status_q});

`ifndef SYNTHESIS
	// Push writes and queue or search reads never share a cycle
	a_ram_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("entry RAM written and read together");

	// Fill count of the addressed queue stays within the depth
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |-> (fill_sel <= DEPTH_C))
		else $error("fill count beyond queue depth");

	// Reads stay inside the entry store
	a_raddr_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_re |-> (ram_raddr < ENTRIES))
		else $error("entry RAM read out of range");
`endif

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps
// Testbench of multi_queue_ring_buffer_with_search_core: a directed table, then random
// request streams under several active queue counts, checked against a queue bank predictor.
// Depends on mqrbs_pkg and the core RTL.
module testbench;
	import mqrbs_pkg::*;

	localparam int N_QUEUES = 8;
	localparam int Q_DEPTH  = 8;
	localparam logic [REQ_W-1:0] REQ_UNUSED_6 = 3'd6;
	localparam logic [REQ_W-1:0] REQ_UNUSED_7 = 3'd7;
	localparam int PRESSURE_AT     = 300;
	localparam int PRESSURE_CYCLES = 400;

	typedef struct packed {
		logic [REQ_W-1:0]  req;
		logic [QIDX_W-1:0] qidx;
		logic [LOC_W-1:0]  loc;
		logic [PAY_W-1:0]  pay;
	} request_t;

	typedef struct packed {
		logic [STAT_W-1:0] st;
		logic [LOC_W-1:0]  loc;
		logic [PAY_W-1:0]  pay;
		logic [LEN_W-1:0]  len;
		logic              found;
	} result_t;

	typedef struct packed {
		request_t rq;
		logic     typed;
		result_t  res;
	} step_t;

	localparam result_t UNCHECKED = '{STAT_OK, 16'h0, 32'h0, 4'h0, 1'b0};

	// Directed items, worked with the reset queue count of eight
	localparam int N_DIRECTED = 24;
	localparam step_t DIRECTED [N_DIRECTED] = '{
		'{'{REQ_LENGTH,    3'd0, 16'h0000, 32'h0000_0000}, 1'b1,
			'{STAT_OK,        16'h0, 32'h0, 4'd0, 1'b0}},
		'{'{REQ_POP,       3'd0, 16'h0000, 32'h0000_0000}, 1'b1,
			'{STAT_EMPTY,     16'h0, 32'h0, 4'd0, 1'b0}},
		'{'{REQ_PEEK_HEAD, 3'd7, 16'hFFFF, 32'hFFFF_FFFF}, 1'b1,
			'{STAT_EMPTY,     16'h0, 32'h0, 4'd0, 1'b0}},
		'{'{REQ_PEEK_TAIL, 3'd3, 16'h0000, 32'h0000_0000}, 1'b1,
			'{STAT_EMPTY,     16'h0, 32'h0, 4'd0, 1'b0}},
		'{'{REQ_SEARCH,    3'd0, 16'h0000, 32'h0000_0000}, 1'b1,
			'{STAT_OK,        16'h0, 32'h0, 4'd0, 1'b0}},
		'{'{REQ_UNUSED_6,  3'd0, 16'h1111, 32'h2222_2222}, 1'b1,
			'{STAT_BAD_INDEX, 16'h0, 32'h0, 4'd0, 1'b0}},
		'{'{REQ_UNUSED_7,  3'd7, 16'hFFFF, 32'hFFFF_FFFF}, 1'b1,
			'{STAT_BAD_INDEX, 16'h0, 32'h0, 4'd0, 1'b0}},
		'{'{REQ_PUSH,      3'd7, 16'hFFFF, 32'hFFFF_FFFF}, 1'b0, UNCHECKED},
		'{'{REQ_PUSH,      3'd7, 16'h0000, 32'h0000_0000}, 1'b0, UNCHECKED},
		'{'{REQ_PUSH,      3'd7, 16'hAAAA, 32'h5555_5555}, 1'b0, UNCHECKED},
		'{'{REQ_PUSH,      3'd7, 16'h5555, 32'hAAAA_AAAA}, 1'b0, UNCHECKED},
		'{'{REQ_PUSH,      3'd7, 16'h0001, 32'h8000_0000}, 1'b0, UNCHECKED},
		'{'{REQ_PUSH,      3'd7, 16'h8000, 32'h0000_0001}, 1'b0, UNCHECKED},
		'{'{REQ_PUSH,      3'd7, 16'h1234, 32'hDEAD_BEEF}, 1'b0, UNCHECKED},
		'{'{REQ_PUSH,      3'd7, 16'h00FF, 32'h0F0F_0F0F}, 1'b0, UNCHECKED},
		// queue seven is now full
		'{'{REQ_PUSH,      3'd7, 16'h4321, 32'h1357_9BDF}, 1'b1,
			'{STAT_FULL,      16'h0, 32'h0, 4'd8, 1'b0}},
		'{'{REQ_PEEK_HEAD, 3'd7, 16'h0000, 32'h0000_0000}, 1'b0, UNCHECKED},
		'{'{REQ_PEEK_TAIL, 3'd7, 16'h0000, 32'h0000_0000}, 1'b0, UNCHECKED},
		'{'{REQ_SEARCH,    3'd2, 16'hFFFF, 32'h0000_0000}, 1'b0, UNCHECKED},
		'{'{REQ_POP,       3'd7, 16'h0000, 32'h0000_0000}, 1'b0, UNCHECKED},
		'{'{REQ_SEARCH,    3'd0, 16'hFFFF, 32'h0000_0000}, 1'b0, UNCHECKED},
		'{'{REQ_PUSH,      3'd0, 16'h00FF, 32'h0000_0001}, 1'b0, UNCHECKED},
		'{'{REQ_LENGTH,    3'd0, 16'h0000, 32'h0000_0000}, 1'b0, UNCHECKED},
		'{'{REQ_SEARCH,    3'd5, 16'h7777, 32'h0000_0000}, 1'b0, UNCHECKED}
	};

	// Random phases: active queue count written, then items sent under it
	localparam int N_PHASES = 5;
	localparam int PHASE_ACTIVE [N_PHASES] = '{15, 1, 0, 3, 8};
	localparam int PHASE_ITEMS  [N_PHASES] = '{150, 100, 40, 200, 260};

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	// s_tdata: req_type, queue_index, location_id, goal_payload, zero pad
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   m_tvalid;
	logic                   m_tready;
	// m_tdata: status, out_location, out_payload, out_length, found, zero pad
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_we;
	logic [ACT_W-1:0]       cfg_wdata;

	// Predictor state of the queue bank
	logic [LOC_W-1:0] loc_mem [N_QUEUES][Q_DEPTH];
	logic [PAY_W-1:0] pay_mem [N_QUEUES][Q_DEPTH];
	int               head_at [N_QUEUES] = '{default: 0};
	int               fill_lvl [N_QUEUES] = '{default: 0};
	int               act_cnt = int'(ACT_RESET);

	result_t due_results [$];
	int      mismatches = 0;
	int      results_seen = 0;
	bit      send_calm = 1'b0;
	bit      recv_calm = 1'b0;

	multi_queue_ring_buffer_with_search_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Work one request on the predicted queue bank and return its result
	function automatic result_t apply_request(request_t rq);
		int      nq;
		int      q;
		int      slot;
		result_t r;
		nq = (act_cnt > N_QUEUES) ? N_QUEUES : act_cnt;
		q = int'(rq.qidx);
		r = UNCHECKED;
		if (rq.req == REQ_SEARCH) begin
			for (int qi = 0; qi < nq; qi++)
				for (int i = 0; i < fill_lvl[qi]; i++)
					if (loc_mem[qi][(head_at[qi] + i) % Q_DEPTH] == rq.loc)
						r.found = 1'b1;
			return r;
		end
		if (rq.req > REQ_SEARCH || q >= nq) begin
			r.st = STAT_BAD_INDEX;
			return r;
		end
		case (rq.req)
			REQ_PUSH: begin
				if (fill_lvl[q] >= Q_DEPTH) begin
					r.st = STAT_FULL;
				end else begin
					slot = (head_at[q] + fill_lvl[q]) % Q_DEPTH;
					loc_mem[q][slot] = rq.loc;
					pay_mem[q][slot] = rq.pay;
					fill_lvl[q]++;
				end
				r.len = LEN_W'(fill_lvl[q]);
			end
			REQ_POP, REQ_PEEK_HEAD, REQ_PEEK_TAIL: begin
				if (fill_lvl[q] == 0) begin
					r.st = STAT_EMPTY;
				end else begin
					if (rq.req == REQ_PEEK_TAIL)
						slot = (head_at[q] + fill_lvl[q] - 1) % Q_DEPTH;
					else
						slot = head_at[q];
					r.loc = loc_mem[q][slot];
					r.pay = pay_mem[q][slot];
					if (rq.req == REQ_POP) begin
						head_at[q] = (head_at[q] + 1) % Q_DEPTH;
						fill_lvl[q]--;
					end
					r.len = LEN_W'(fill_lvl[q]);
				end
			end
			default: r.len = LEN_W'(fill_lvl[q]);
		endcase
		return r;
	endfunction

	// Idle cycles before the next item; now and then flip into or out of a calm stretch
	function automatic int draw_gap(inout bit calm);
		if ($urandom_range(0, 29) == 0)
			calm = !calm;
		return calm ? 0 : int'($urandom_range(0, 19));
	endfunction

	// Pick a location: full range, a small cluster, or one near the top
	function automatic logic [LOC_W-1:0] draw_location();
		case ($urandom_range(0, 2))
			0: return LOC_W'($urandom);
			1: return LOC_W'($urandom_range(0, 15));
			default: return 16'hFFF0 | LOC_W'($urandom_range(0, 15));
		endcase
	endfunction

	// Random request, biased towards sequences that fill and drain the queues
	function automatic request_t draw_request(int push_pct);
		request_t rq;
		int       lim;
		int       pick;
		int       qi;
		lim = (act_cnt > N_QUEUES) ? N_QUEUES : act_cnt;
		rq.pay = $urandom;
		rq.loc = draw_location();
		if (lim == 0 || $urandom_range(0, 9) == 0)
			rq.qidx = QIDX_W'($urandom_range(0, N_QUEUES - 1));
		else
			rq.qidx = QIDX_W'($urandom_range(0, lim - 1));
		pick = int'($urandom_range(0, 99));
		if (pick < push_pct) begin
			rq.req = REQ_PUSH;
			return rq;
		end
		pick = int'($urandom_range(0, 99));
		if (pick < 30)
			rq.req = REQ_POP;
		else if (pick < 45)
			rq.req = REQ_PEEK_HEAD;
		else if (pick < 57)
			rq.req = REQ_PEEK_TAIL;
		else if (pick < 67)
			rq.req = REQ_LENGTH;
		else if (pick < 92)
			rq.req = REQ_SEARCH;
		else
			rq.req = $urandom_range(0, 1) ? REQ_UNUSED_7 : REQ_UNUSED_6;
		// aim most searches at a live stored location of any queue, active or not
		if (rq.req == REQ_SEARCH && $urandom_range(0, 2) != 0) begin
			qi = int'($urandom_range(0, N_QUEUES - 1));
			if (fill_lvl[qi] > 0)
				rq.loc = loc_mem[qi][(head_at[qi]
					+ int'($urandom_range(0, fill_lvl[qi] - 1))) % Q_DEPTH];
		end
		return rq;
	endfunction

	// Offer one item and queue its expected result once accepted
	task automatic offer_request(input request_t rq, input bit typed, input result_t fixed);
		int      gap;
		result_t want;
		gap = draw_gap(send_calm);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(IN_TDATA_W - IN_BITS){1'b0}}, rq.pay, rq.loc, rq.qidx, rq.req};
		do @(posedge clk); while (!s_tready);
		want = apply_request(rq);
		due_results.insert(due_results.size(), typed ? fixed : want);
	endtask

	// Wait until every expected result is in, then let the block settle
	task automatic settle(input int extra);
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	function automatic bit field_ok(string name, logic [31:0] want, logic [31:0] got);
		if (want === got)
			return 1'b1;
		$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
		return 1'b0;
	endfunction

	// Stimulus: reset, directed table, then random phases
	initial begin
		int push_pct;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++)
			offer_request(DIRECTED[i].rq, DIRECTED[i].typed, DIRECTED[i].res);
		s_tvalid <= 1'b0;

		push_pct = 40;
		for (int p = 0; p < N_PHASES; p++) begin
			settle(4);
			cfg_we <= 1'b1;
			cfg_wdata <= ACT_W'(PHASE_ACTIVE[p]);
			@(posedge clk);
			cfg_we <= 1'b0;
			act_cnt = PHASE_ACTIVE[p];
			for (int n = 0; n < PHASE_ITEMS[p]; n++) begin
				// swing between filling and draining every fifty items
				if (n % 50 == 0)
					case ($urandom_range(0, 2))
						0: push_pct = 20;
						1: push_pct = 45;
						default: push_pct = 70;
					endcase
				offer_request(draw_request(push_pct), 1'b0, UNCHECKED);
			end
			s_tvalid <= 1'b0;
		end

		settle(100);
		if (mismatches == 0)
			$display("** multi_queue_ring_buffer_with_search_core: PASSED **");
		else
			$display("** multi_queue_ring_buffer_with_search_core: FAILED **");
		$finish;
	end

	// Result side: random back-pressure, one long hold-off, field by field check
	initial begin
		int      gap;
		bit      held_off;
		bit      ok;
		result_t got;
		result_t want;
		held_off = 1'b0;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = draw_gap(recv_calm);
			if (!held_off && results_seen >= PRESSURE_AT) begin
				held_off = 1'b1;
				m_tready <= 1'b0;
				repeat (PRESSURE_CYCLES) @(posedge clk);
			end else if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			results_seen++;
			got.st    = m_tdata[1:0];
			got.loc   = m_tdata[17:2];
			got.pay   = m_tdata[49:18];
			got.len   = m_tdata[53:50];
			got.found = m_tdata[54];
			if (due_results.size() == 0) begin
				$display("%0t: result with no request outstanding, expected none, got %h",
					$time, m_tdata);
				mismatches++;
			end else begin
				want = due_results[0];
				due_results.delete(0);
				ok = field_ok("status", 32'(want.st), 32'(got.st));
				ok &= field_ok("out_location", 32'(want.loc), 32'(got.loc));
				ok &= field_ok("out_payload", want.pay, got.pay);
				ok &= field_ok("out_length", 32'(want.len), 32'(got.len));
				ok &= field_ok("found", 32'(want.found), 32'(got.found));
				if (!ok)
					mismatches++;
			end
		end
	end

	// Hang guard
	initial begin
		#(20_000_000);
		$display("** multi_queue_ring_buffer_with_search_core: FAILED **");
		$finish;
	end

endmodule

/* files.f */
rtl/mqrbs_pkg.sv
rtl/mqrbs_ram.sv
rtl/mqrbs_ctrl.sv
rtl/mqrbs_dp.sv
rtl/multi_queue_ring_buffer_with_search_core.sv
bench/testbench.sv
